### src/gepk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge point keys: shared definitions
// Widths, codes and the item types passed between the front, queue and back.
// ----------------------------------------------------------------------------
package gepk_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LABEL_W    = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NUM_DIRS   = 4;
  localparam int unsigned NUM_KINDS  = 4;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 280;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  localparam logic [LABEL_W-1:0] HASH_MUL = 32'd2654435761;
  localparam logic [PIX_W:0]     EDGE_SUM = 9'd255;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] WIDTH_LIMIT  = 12'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 12'(MAX_HEIGHT);

  // Register indexes of the configuration port.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Direction codes carried in bits 2:1 of a boundary word.
  localparam logic [1:0] DIR_RIGHT      = 2'd0;
  localparam logic [1:0] DIR_DOWN_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN       = 2'd2;
  localparam logic [1:0] DIR_DOWN_LEFT  = 2'd3;

  // Result kinds of one request, in delivery order.
  localparam int unsigned KIND_UPPER_MID = 0;
  localparam int unsigned KIND_UPPER_END = 1;
  localparam int unsigned KIND_LOWER_MID = 2;
  localparam int unsigned KIND_LOWER_END = 3;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [PIX_W-1:0]   value;
  } sample_t;

  typedef struct packed {
    sample_t              cur;
    sample_t              left1;
    sample_t              prev_left;
    sample_t              prev_cur;
    sample_t              down_left;
    sample_t              left_or_cur;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [NUM_KINDS-1:0] kinds;
  } job_t;

endpackage

### src/gradient_edge_point_keys.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge point keys
// Emits four boundary words per pixel of a labelled, thresholded raster.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the slave stream, one request per pixel with
// its value and component label. For every pixel of the frame one result
// leaves on the master stream: the pixel position and its boundary words
// toward the right, down-right, down and down-left neighbours; tlast marks the
// final result caused by one input pixel. Results trail the input by one row
// and one column; a row end adds a result for the last column and the final
// row of a frame is emitted as it arrives, so one pixel gives zero to four
// results. Results pass through the request queue, the compare stage and the
// output register. The back end delivers one result per cycle while the
// receiver is ready, so a pixel giving one result is then taken every cycle;
// row ends and the final row are bounded by the four-entry request queue. Frame
// width and height are to be written on the configuration port only while idle;
// the block does not enforce it. Reset clears the raster position, the queue
// and the output stage; the previous-row store needs no clearing. A stalled
// receiver holds the result in place; input is still taken until the queue fills.
// ----------------------------------------------------------------------------
module gradient_edge_point_keys (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_value, component_label
  input  logic [gepk_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // center_x, center_y, word_right, word_down_right, word_down,
  // word_down_left, two zero bits
  output logic [gepk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [gepk_pkg::CFG_W-1:0]          cfg_data_i
);

  logic [gepk_pkg::CFG_W-1:0] width_q, height_q;
  logic [gepk_pkg::CFG_W-1:0] width_eff, height_eff;
  gepk_pkg::sample_t          in_sample;
  gepk_pkg::job_t             push_job, head_job;
  logic                       push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gepk_pkg::WIDTH_RESET;
      height_q <= gepk_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gepk_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        gepk_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = (width_q == '0) ? 12'd1 :
                      (width_q > gepk_pkg::WIDTH_LIMIT) ? gepk_pkg::WIDTH_LIMIT : width_q;
  assign height_eff = (height_q == '0) ? 12'd1 :
                      (height_q > gepk_pkg::HEIGHT_LIMIT) ? gepk_pkg::HEIGHT_LIMIT : height_q;

  assign in_sample.value = s_axis_tdata[7:0];
  assign in_sample.label = s_axis_tdata[39:8];

  gepk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (in_sample),
    .full_i      (full),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  gepk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .valid_o     (head_valid),
    .pop_i       (pop),
    .head_o      (head_job)
  );

  gepk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### src/gepk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module gepk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gepk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge point keys: front end
// Accepts pixels, tracks the raster position, keeps the previous row and the
// sliding window, and queues one request per pixel that produces results.
// ----------------------------------------------------------------------------
module gepk_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gepk_pkg::CFG_W-1:0]   width_i,
  input  logic [gepk_pkg::CFG_W-1:0]   height_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gepk_pkg::sample_t            in_sample_i,
  input  logic                         full_i,
  output logic                         job_valid_o,
  output gepk_pkg::job_t               job_o
);

  logic                          accept;
  logic [gepk_pkg::COL_W-1:0]    col_q, col_d;
  logic [gepk_pkg::ROW_W-1:0]    row_q, row_d;
  logic [gepk_pkg::CFG_W-1:0]    col_inc, row_inc;
  logic                          last_col, last_row;
  logic                          col_ge1, col_ge2;
  logic                          fwd_q, fwd_d;
  gepk_pkg::sample_t             fwd_data_q, fwd_data_d;
  gepk_pkg::sample_t             ram_rdata;
  gepk_pkg::sample_t             prev_cur;
  gepk_pkg::sample_t             win_left1_q, win_left2_q, win_prev_left_q;
  logic [gepk_pkg::NUM_KINDS-1:0] kinds;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign col_inc  = {1'b0, col_q} + 12'd1;
  assign row_inc  = {1'b0, row_q} + 12'd1;
  assign last_col = col_inc >= width_i;
  assign last_row = row_inc >= height_i;
  assign col_ge1  = col_q != '0;
  assign col_ge2  = col_q[gepk_pkg::COL_W-1:1] != '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[gepk_pkg::ROW_W-1:0];
      end else begin
        col_d = col_inc[gepk_pkg::COL_W-1:0];
      end
    end
  end

  // The row store cannot return a word written in the same cycle, so a
  // single-column frame takes the previous value from a bypass register.
  assign fwd_d      = accept ? (col_d == col_q) : fwd_q;
  assign fwd_data_d = accept ? in_sample_i : fwd_data_q;
  assign prev_cur   = fwd_q ? fwd_data_q : ram_rdata;

  gepk_ram #(
    .WIDTH ($bits(gepk_pkg::sample_t)),
    .DEPTH (gepk_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (in_sample_i),
    .re_i    (accept),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
    if (accept) begin
      win_left1_q     <= in_sample_i;
      win_left2_q     <= win_left1_q;
      win_prev_left_q <= prev_cur;
    end
  end

  assign kinds[gepk_pkg::KIND_UPPER_MID] = (row_q != '0) && col_ge1;
  assign kinds[gepk_pkg::KIND_UPPER_END] = (row_q != '0) && last_col;
  assign kinds[gepk_pkg::KIND_LOWER_MID] = last_row && col_ge1;
  assign kinds[gepk_pkg::KIND_LOWER_END] = last_row && last_col;

  assign job_valid_o       = accept && (kinds != '0);
  assign job_o.cur         = in_sample_i;
  assign job_o.left1       = win_left1_q;
  assign job_o.prev_left   = win_prev_left_q;
  assign job_o.prev_cur    = prev_cur;
  assign job_o.down_left   = col_ge2 ? win_left2_q : win_left1_q;
  assign job_o.left_or_cur = col_ge1 ? win_left1_q : in_sample_i;
  assign job_o.col         = col_q;
  assign job_o.row         = row_q;
  assign job_o.kinds       = kinds;

endmodule

### src/gepk_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge point keys: request queue
// A short first-in first-out queue of requests between front and back.
// ----------------------------------------------------------------------------
module gepk_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gepk_pkg::job_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output gepk_pkg::job_t head_o
);

  gepk_pkg::job_t                   mem_q [gepk_pkg::FIFO_DEPTH];
  logic [gepk_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [gepk_pkg::FIFO_PTR_W:0]    count_q, count_d;
  logic                             do_pop;

  assign full_o  = count_q == (gepk_pkg::FIFO_PTR_W + 1)'(gepk_pkg::FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/gepk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge point keys: back end
// Walks the result kinds of each request, compares the pixel pairs, hashes
// the label pairs and forms the four boundary words of every result.
// ----------------------------------------------------------------------------
module gepk_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  input  gepk_pkg::job_t                      job_i,
  output logic                                job_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gepk_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_last_o
);

  logic [gepk_pkg::NUM_KINDS-1:0] done_q, done_d;
  logic [gepk_pkg::NUM_KINDS-1:0] active, pick;
  logic                           issue, issue_last;
  logic                           out_free, a_free;

  gepk_pkg::sample_t              centre;
  gepk_pkg::sample_t              nbr [gepk_pkg::NUM_DIRS];
  logic [gepk_pkg::COL_W-1:0]     sel_x;
  logic [gepk_pkg::ROW_W-1:0]     sel_y;

  logic                           a_valid_q;
  logic                           a_last_q;
  logic [gepk_pkg::COL_W-1:0]     a_x_q;
  logic [gepk_pkg::ROW_W-1:0]     a_y_q;
  logic [gepk_pkg::NUM_DIRS-1:0]  a_hit_q, a_gt_q;
  logic [gepk_pkg::LABEL_W-1:0]   a_lab_q [gepk_pkg::NUM_DIRS];

  logic [gepk_pkg::WORD_W-1:0]    word [gepk_pkg::NUM_DIRS];
  logic                           m_valid_q;
  logic                           m_last_q;
  logic [gepk_pkg::OUT_DATA_W-1:0] m_data_q;

  assign out_free = !m_valid_q || out_ready_i;
  assign a_free   = !a_valid_q || out_free;

  assign active = job_i.kinds & ~done_q;

  always_comb begin
    pick = '0;
    if (active[gepk_pkg::KIND_UPPER_MID]) begin
      pick[gepk_pkg::KIND_UPPER_MID] = 1'b1;
    end else if (active[gepk_pkg::KIND_UPPER_END]) begin
      pick[gepk_pkg::KIND_UPPER_END] = 1'b1;
    end else if (active[gepk_pkg::KIND_LOWER_MID]) begin
      pick[gepk_pkg::KIND_LOWER_MID] = 1'b1;
    end else begin
      pick[gepk_pkg::KIND_LOWER_END] = 1'b1;
    end
  end

  assign issue      = job_valid_i && a_free;
  assign issue_last = (active & ~pick) == '0;
  assign job_pop_o  = issue && issue_last;

  always_comb begin
    done_d = done_q;
    if (issue) begin
      done_d = issue_last ? '0 : (done_q | pick);
    end
  end

  always_comb begin
    centre = job_i.cur;
    nbr[0] = job_i.cur;
    nbr[1] = job_i.cur;
    nbr[2] = job_i.cur;
    nbr[3] = job_i.left_or_cur;
    sel_x  = job_i.col;
    sel_y  = job_i.row;
    if (pick[gepk_pkg::KIND_UPPER_MID]) begin
      centre = job_i.prev_left;
      nbr[0] = job_i.prev_cur;
      nbr[1] = job_i.cur;
      nbr[2] = job_i.left1;
      nbr[3] = job_i.down_left;
      sel_x  = job_i.col - 11'd1;
      sel_y  = job_i.row - 11'd1;
    end else if (pick[gepk_pkg::KIND_UPPER_END]) begin
      centre = job_i.prev_cur;
      nbr[0] = job_i.prev_cur;
      sel_y  = job_i.row - 11'd1;
    end else if (pick[gepk_pkg::KIND_LOWER_MID]) begin
      centre = job_i.left1;
      nbr[2] = job_i.left1;
      nbr[3] = job_i.down_left;
      sel_x  = job_i.col - 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (a_free) begin
        a_valid_q <= issue;
      end
      if (out_free) begin
        m_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_last_q <= issue_last;
      a_x_q    <= sel_x;
      a_y_q    <= sel_y;
      for (int d = 0; d < gepk_pkg::NUM_DIRS; d++) begin
        a_hit_q[d] <= ({1'b0, centre.value} + {1'b0, nbr[d].value}) == gepk_pkg::EDGE_SUM;
        a_gt_q[d]  <= nbr[d].value > centre.value;
        a_lab_q[d] <= (centre.label > nbr[d].label) ? centre.label : nbr[d].label;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < gepk_pkg::NUM_DIRS; d++) begin
      logic [gepk_pkg::LABEL_W-1:0] hash;
      hash    = a_lab_q[d] * gepk_pkg::HASH_MUL;
      word[d] = '0;
      if (a_hit_q[d]) begin
        word[d] = {hash, 7'b0, a_x_q, a_y_q, 2'(d), a_gt_q[d]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && a_valid_q) begin
      m_last_q <= a_last_q;
      m_data_q <= {2'b0, word[gepk_pkg::DIR_DOWN_LEFT], word[gepk_pkg::DIR_DOWN],
                   word[gepk_pkg::DIR_DOWN_RIGHT], word[gepk_pkg::DIR_RIGHT],
                   a_y_q, a_x_q};
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_data_q;
  assign out_last_o  = m_last_q;

endmodule
